// File: rtl/core/tpxp_pkg.sv
// Shared types, constants and a helper function for the parent x placement block.
package tpxp_pkg;

    // Field widths of the stream words.
    localparam int X_W        = 32;
    localparam int W_W        = 24;
    localparam int CENTER_W   = X_W + 1;
    localparam int MODE_W     = 2;
    localparam int IN_DATA_W  = X_W + W_W + W_W;
    localparam int OUT_DATA_W = X_W;

    // Width of the intermediate values that feed the final saturation.
    localparam int SAT_W = 48;

    // Default store depth.
    localparam int DEF_MAX_CHILDREN = 64;

    // Placement rules held in the mode register.
    localparam logic [MODE_W-1:0] MODE_CENTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BARY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd2;

    // Status codes of a result word.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_OVERFLOW = 1'b1;

    // Status of the divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Clamp a wide two's complement value to the signed 32-bit range.
    function automatic logic [X_W-1:0] sat_q32(input logic [SAT_W-1:0] v);
        logic [SAT_W-X_W:0] top;
        top = v[SAT_W-1:X_W-1];
        if (top == '0 || top == '1) begin
            return v[X_W-1:0];
        end else if (v[SAT_W-1]) begin
            return {1'b1, {(X_W-1){1'b0}}};
        end else begin
            return {1'b0, {(X_W-1){1'b1}}};
        end
    endfunction

endpackage

// File: rtl/core/tpxp_center_ram.sv
// Store of child centres: one write port and one registered read port.
module tpxp_center_ram #(
    parameter int DEPTH  = tpxp_pkg::DEF_MAX_CHILDREN,
    parameter int ADDR_W = $clog2(tpxp_pkg::DEF_MAX_CHILDREN),
    parameter int DATA_W = tpxp_pkg::CENTER_W
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered: data valid in the cycle after the address.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/tpxp_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle, truncating towards zero.
module tpxp_divider #(
    parameter int DIVIDEND_W = 39,
    parameter int DIVISOR_W  = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DIVIDEND_W-1:0] i_dividend,
    input  logic        [DIVISOR_W-1:0]  i_divisor,
    output tpxp_pkg::t_div_stat          o_stat,
    output logic signed [DIVIDEND_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic                  r_neg;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W+1:0]  diff;
    logic                  ge;

    // One trial subtraction per cycle.
    always_comb begin
        rem_sh = {r_rem, r_quo[DIVIDEND_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_div};
        ge     = ~diff[DIVISOR_W+1];
    end

    // Control: busy until every dividend bit has been stepped through, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitudes are divided, the sign is put back at the output.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DIVIDEND_W-1];
            r_quo <= i_dividend[DIVIDEND_W-1] ? -i_dividend : i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_neg ? -signed'(r_quo) : signed'(r_quo);

endmodule

// File: rtl/core/tree_parent_x_placement.sv
// Top level: places a parent node over its children streamed left to right.
//
//  Channel   Direction  Handshake                  Contents
//  s         in         i_s_tvalid / o_s_tready    child word, tlast marks last child
//  m         out        o_m_tvalid / i_m_tready    parent x word, tuser is status
//  cfg       in         i_cfg_wr_en                placement mode register
//
// Each child word is captured, then its centre is stored and the running
// sum updated while the store has room. On the last child the centre,
// single-child and overflow cases go straight to the final state, the
// median passes the read states (two reads of the centre store) and the
// barycentre waits for the bit-serial divider. Reset is synchronous and
// clears the group state; a stalled output word holds the final state.
module tree_parent_x_placement #(
    parameter int MAX_CHILDREN = tpxp_pkg::DEF_MAX_CHILDREN
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // child_x [31:0], child_width [55:32], parent_width [79:56]
    input  logic [tpxp_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic                               i_s_tlast,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // parent_x [31:0]
    output logic [tpxp_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // status [0]
    output logic                               o_m_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    input  logic                               i_cfg_wr_en,
    input  logic [tpxp_pkg::MODE_W-1:0]        i_cfg_wr_data
);

    localparam int X_W    = tpxp_pkg::X_W;
    localparam int W_W    = tpxp_pkg::W_W;
    localparam int C_W    = tpxp_pkg::CENTER_W;
    localparam int SAT_W  = tpxp_pkg::SAT_W;
    localparam int CNT_W  = $clog2(MAX_CHILDREN + 1);
    localparam int ADDR_W = $clog2(MAX_CHILDREN);
    localparam int SUM_W  = C_W + $clog2(MAX_CHILDREN);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ACC    = 3'd1;
    localparam logic [2:0] ST_DSTART = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_RD0    = 3'd4;
    localparam logic [2:0] ST_RD1    = 3'd5;
    localparam logic [2:0] ST_RD2    = 3'd6;
    localparam logic [2:0] ST_FIN    = 3'd7;

    // Rule chosen for the final cycle.
    localparam logic [2:0] KIND_OVF    = 3'd0;
    localparam logic [2:0] KIND_SINGLE = 3'd1;
    localparam logic [2:0] KIND_CENTER = 3'd2;
    localparam logic [2:0] KIND_BARY   = 3'd3;
    localparam logic [2:0] KIND_MEDIAN = 3'd4;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [2:0]                   r_kind;
    logic [2:0]                   n_kind;
    logic [tpxp_pkg::MODE_W-1:0]  r_mode;

    logic [X_W-1:0]               r_x;
    logic [W_W-1:0]               r_w;
    logic [W_W-1:0]               r_pw;
    logic                         r_last;

    logic [C_W-1:0]               r_c;
    logic [SUM_W-1:0]             r_sum;
    logic [CNT_W-1:0]             r_count;
    logic [X_W-1:0]               r_first;
    logic                         r_ovf;
    logic [C_W-1:0]               r_med0;
    logic [C_W-1:0]               r_med1;

    logic                         r_out_valid;
    logic [X_W-1:0]               r_out_data;
    logic                         r_out_status;

    logic [C_W-1:0]               c_now;
    logic                         can_store;
    logic [CNT_W-1:0]             med_m;
    logic [ADDR_W-1:0]            rd_addr;
    logic [C_W-1:0]               ram_rdata;
    logic                         ram_we;
    logic                         div_start;
    tpxp_pkg::t_div_stat          div_stat;
    logic signed [SUM_W-1:0]      div_quo;
    logic                         out_free;

    logic [SAT_W-1:0]             h_ext;
    logic [SAT_W-1:0]             span;
    logic [SAT_W-1:0]             med_pair;
    logic [SAT_W-1:0]             px_wide;
    logic [X_W-1:0]               px_sat;

    // Centre of the captured child, room left in the store, median index and whether the output register is free.
    always_comb begin
        c_now     = {r_x[X_W-1], r_x} + C_W'(r_w[W_W-1:1]);
        can_store = (r_count < CNT_W'(MAX_CHILDREN));
        med_m     = r_count >> 1;
        out_free  = !r_out_valid || i_m_tready;
    end

    // Store address for the median reads: lower middle first when even.
    always_comb begin
        if (r_state == ST_RD0 && !r_count[0]) begin
            rd_addr = med_m[ADDR_W-1:0] - 1'b1;
        end else begin
            rd_addr = med_m[ADDR_W-1:0];
        end
    end

    assign ram_we    = (r_state == ST_ACC) && can_store;
    assign div_start = (r_state == ST_DSTART);

    tpxp_center_ram #(
        .DEPTH  (MAX_CHILDREN),
        .ADDR_W (ADDR_W),
        .DATA_W (C_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (c_now),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    tpxp_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // Sequencer next state and rule selection.
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (r_ovf || !can_store) begin
                    n_kind  = KIND_OVF;
                    n_state = ST_FIN;
                end else if (r_count == '0) begin
                    n_kind  = KIND_SINGLE;
                    n_state = ST_FIN;
                end else if (r_mode == tpxp_pkg::MODE_BARY) begin
                    n_kind  = KIND_BARY;
                    n_state = ST_DSTART;
                end else if (r_mode == tpxp_pkg::MODE_MEDIAN) begin
                    n_kind  = KIND_MEDIAN;
                    n_state = ST_RD0;
                end else begin
                    n_kind  = KIND_CENTER;
                    n_state = ST_FIN;
                end
            end
            ST_DSTART: n_state = ST_DIV;
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = ST_FIN;
                end
            end
            ST_RD0:  n_state = ST_RD1;
            ST_RD1:  n_state = ST_RD2;
            ST_RD2:  n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Final arithmetic for the chosen rule, then saturation.
    always_comb begin
        h_ext    = SAT_W'(r_pw[W_W-1:1]);
        span     = SAT_W'(signed'(r_first)) + SAT_W'(signed'(r_x))
                   + SAT_W'(r_w) - SAT_W'(r_pw);
        med_pair = SAT_W'(signed'(r_med0)) + SAT_W'(signed'(r_med1));
        case (r_kind)
            KIND_SINGLE: px_wide = SAT_W'(signed'(r_c)) - h_ext;
            KIND_CENTER: px_wide = {span[SAT_W-1], span[SAT_W-1:1]};
            KIND_BARY:   px_wide = SAT_W'(div_quo) - h_ext;
            KIND_MEDIAN: begin
                if (r_count[0]) begin
                    px_wide = SAT_W'(signed'(r_med0)) - h_ext;
                end else begin
                    px_wide = {med_pair[SAT_W-1], med_pair[SAT_W-1:1]} - h_ext;
                end
            end
            default:     px_wide = '0;
        endcase
        px_sat = tpxp_pkg::sat_q32(px_wide);
    end

    // Control registers: state, mode, group bookkeeping and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= KIND_OVF;
            r_mode      <= tpxp_pkg::MODE_CENTER;
            r_sum       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_first     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            // A new word loads the output register; an accepted one leaves it.
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_ACC: begin
                    if (r_count == '0) begin
                        r_first <= r_x;
                    end
                    if (can_store) begin
                        r_sum   <= r_sum + SUM_W'(signed'(c_now));
                        r_count <= r_count + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_sum       <= '0;
                        r_count     <= '0;
                        r_ovf       <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers: captured word, centres and the output word.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_s_tvalid) begin
            r_x    <= i_s_tdata[X_W-1:0];
            r_w    <= i_s_tdata[X_W+W_W-1:X_W];
            r_pw   <= i_s_tdata[X_W+2*W_W-1:X_W+W_W];
            r_last <= i_s_tlast;
        end
        if (r_state == ST_ACC) begin
            r_c <= c_now;
        end
        if (r_state == ST_RD1) begin
            r_med0 <= ram_rdata;
        end
        if (r_state == ST_RD2) begin
            r_med1 <= ram_rdata;
        end
        if (r_state == ST_FIN && out_free) begin
            if (r_kind == KIND_OVF) begin
                r_out_data   <= '0;
                r_out_status <= tpxp_pkg::STATUS_OVERFLOW;
            end else begin
                r_out_data   <= px_sat;
                r_out_status <= tpxp_pkg::STATUS_OK;
            end
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

endmodule
